### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define STH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define STH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sth_pkg.sv
`timescale 1ns / 1ps

package sth_pkg;

    localparam int FACE_INDEX_BITS_DEF = 16;
    localparam int CRD_W     = 32;
    localparam int RANGE_W   = 31;
    localparam int DIFF_W    = 33;
    localparam int S_W       = 47;
    localparam int CROSS_W   = 67;
    localparam int OPA_W     = 68;
    localparam int OPB_W     = 48;
    localparam int DIG_W     = 16;
    localparam int NDIG      = 3;
    localparam int DIG_IDX_W = 2;
    localparam int ACC_W     = 120;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;
    localparam int TQ_W      = 33;
    localparam int PT_SH     = 32;
    localparam int OFF_W     = 49;
    localparam int SUM_W     = 50;
    localparam int CFG_IDX_W = 3;
    localparam int UOP_W     = 6;
    localparam logic [UOP_W-1:0] UOP_GEO_LAST = 6'd41;
    localparam logic [UOP_W-1:0] UOP_LAST     = 6'd44;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z,
        CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z, CFG_SEG_RANGE
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_GEO, ST_ABS, ST_DIV, ST_PNT, ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OPA_DIR_X, OPA_DIR_Y, OPA_DIR_Z,
        OPA_E0_X, OPA_E0_Y, OPA_E0_Z,
        OPA_A0_X, OPA_A0_Y, OPA_A0_Z,
        OPA_A1_X, OPA_A1_Y, OPA_A1_Z,
        OPA_A2_X, OPA_A2_Y, OPA_A2_Z,
        OPA_N_X, OPA_N_Y, OPA_N_Z,
        OPA_C_X, OPA_C_Y, OPA_C_Z,
        OPA_S_X, OPA_S_Y, OPA_S_Z
    } opa_sel_t;

    typedef enum logic [4:0] {
        OPB_RANGE,
        OPB_E1_X, OPB_E1_Y, OPB_E1_Z,
        OPB_A0_X, OPB_A0_Y, OPB_A0_Z,
        OPB_A1_X, OPB_A1_Y, OPB_A1_Z,
        OPB_A2_X, OPB_A2_Y, OPB_A2_Z,
        OPB_S_X, OPB_S_Y, OPB_S_Z,
        OPB_TQ
    } opb_sel_t;

    typedef enum logic [4:0] {
        DST_NONE,
        DST_S_X, DST_S_Y, DST_S_Z,
        DST_N_X, DST_N_Y, DST_N_Z,
        DST_DEN, DST_NUM,
        DST_C_X, DST_C_Y, DST_C_Z,
        DST_EDGE0, DST_EDGE1, DST_EDGE2,
        DST_P_X, DST_P_Y, DST_P_Z
    } dst_t;

    typedef struct packed {
        opa_sel_t a;
        opb_sel_t b;
        logic     sub;
        logic     clr;
        dst_t     dst;
    } uop_t;

    typedef struct packed {
        logic                 in_load;
        logic                 mac_en;
        uop_t                 uop;
        logic [DIG_IDX_W-1:0] digit;
        logic                 abs_load;
        logic                 div_step;
        logic                 out_load;
    } ctrl_cmd_t;

    function automatic uop_t mk_uop(opa_sel_t a, opb_sel_t b, logic sub, logic clr,
                                    dst_t dst);
        uop_t u;
        u.a   = a;
        u.b   = b;
        u.sub = sub;
        u.clr = clr;
        u.dst = dst;
        return u;
    endfunction

    // Multiply-accumulate program: segment vector, normal, den, num, the edge
    // determinant of each triangle edge, then the crossing point.
    function automatic uop_t uop_f(logic [UOP_W-1:0] idx);
        uop_t u;
        unique case (idx)
            6'd0:  u = mk_uop(OPA_DIR_X, OPB_RANGE, 1'b0, 1'b1, DST_S_X);
            6'd1:  u = mk_uop(OPA_DIR_Y, OPB_RANGE, 1'b0, 1'b1, DST_S_Y);
            6'd2:  u = mk_uop(OPA_DIR_Z, OPB_RANGE, 1'b0, 1'b1, DST_S_Z);
            6'd3:  u = mk_uop(OPA_E0_Y, OPB_E1_Z, 1'b0, 1'b1, DST_NONE);
            6'd4:  u = mk_uop(OPA_E0_Z, OPB_E1_Y, 1'b1, 1'b0, DST_N_X);
            6'd5:  u = mk_uop(OPA_E0_Z, OPB_E1_X, 1'b0, 1'b1, DST_NONE);
            6'd6:  u = mk_uop(OPA_E0_X, OPB_E1_Z, 1'b1, 1'b0, DST_N_Y);
            6'd7:  u = mk_uop(OPA_E0_X, OPB_E1_Y, 1'b0, 1'b1, DST_NONE);
            6'd8:  u = mk_uop(OPA_E0_Y, OPB_E1_X, 1'b1, 1'b0, DST_N_Z);
            6'd9:  u = mk_uop(OPA_N_X, OPB_S_X, 1'b0, 1'b1, DST_NONE);
            6'd10: u = mk_uop(OPA_N_Y, OPB_S_Y, 1'b0, 1'b0, DST_NONE);
            6'd11: u = mk_uop(OPA_N_Z, OPB_S_Z, 1'b0, 1'b0, DST_DEN);
            6'd12: u = mk_uop(OPA_N_X, OPB_A0_X, 1'b0, 1'b1, DST_NONE);
            6'd13: u = mk_uop(OPA_N_Y, OPB_A0_Y, 1'b0, 1'b0, DST_NONE);
            6'd14: u = mk_uop(OPA_N_Z, OPB_A0_Z, 1'b0, 1'b0, DST_NUM);
            6'd15: u = mk_uop(OPA_A0_Y, OPB_A1_Z, 1'b0, 1'b1, DST_NONE);
            6'd16: u = mk_uop(OPA_A0_Z, OPB_A1_Y, 1'b1, 1'b0, DST_C_X);
            6'd17: u = mk_uop(OPA_A0_Z, OPB_A1_X, 1'b0, 1'b1, DST_NONE);
            6'd18: u = mk_uop(OPA_A0_X, OPB_A1_Z, 1'b1, 1'b0, DST_C_Y);
            6'd19: u = mk_uop(OPA_A0_X, OPB_A1_Y, 1'b0, 1'b1, DST_NONE);
            6'd20: u = mk_uop(OPA_A0_Y, OPB_A1_X, 1'b1, 1'b0, DST_C_Z);
            6'd21: u = mk_uop(OPA_C_X, OPB_S_X, 1'b0, 1'b1, DST_NONE);
            6'd22: u = mk_uop(OPA_C_Y, OPB_S_Y, 1'b0, 1'b0, DST_NONE);
            6'd23: u = mk_uop(OPA_C_Z, OPB_S_Z, 1'b0, 1'b0, DST_EDGE0);
            6'd24: u = mk_uop(OPA_A1_Y, OPB_A2_Z, 1'b0, 1'b1, DST_NONE);
            6'd25: u = mk_uop(OPA_A1_Z, OPB_A2_Y, 1'b1, 1'b0, DST_C_X);
            6'd26: u = mk_uop(OPA_A1_Z, OPB_A2_X, 1'b0, 1'b1, DST_NONE);
            6'd27: u = mk_uop(OPA_A1_X, OPB_A2_Z, 1'b1, 1'b0, DST_C_Y);
            6'd28: u = mk_uop(OPA_A1_X, OPB_A2_Y, 1'b0, 1'b1, DST_NONE);
            6'd29: u = mk_uop(OPA_A1_Y, OPB_A2_X, 1'b1, 1'b0, DST_C_Z);
            6'd30: u = mk_uop(OPA_C_X, OPB_S_X, 1'b0, 1'b1, DST_NONE);
            6'd31: u = mk_uop(OPA_C_Y, OPB_S_Y, 1'b0, 1'b0, DST_NONE);
            6'd32: u = mk_uop(OPA_C_Z, OPB_S_Z, 1'b0, 1'b0, DST_EDGE1);
            6'd33: u = mk_uop(OPA_A2_Y, OPB_A0_Z, 1'b0, 1'b1, DST_NONE);
            6'd34: u = mk_uop(OPA_A2_Z, OPB_A0_Y, 1'b1, 1'b0, DST_C_X);
            6'd35: u = mk_uop(OPA_A2_Z, OPB_A0_X, 1'b0, 1'b1, DST_NONE);
            6'd36: u = mk_uop(OPA_A2_X, OPB_A0_Z, 1'b1, 1'b0, DST_C_Y);
            6'd37: u = mk_uop(OPA_A2_X, OPB_A0_Y, 1'b0, 1'b1, DST_NONE);
            6'd38: u = mk_uop(OPA_A2_Y, OPB_A0_X, 1'b1, 1'b0, DST_C_Z);
            6'd39: u = mk_uop(OPA_C_X, OPB_S_X, 1'b0, 1'b1, DST_NONE);
            6'd40: u = mk_uop(OPA_C_Y, OPB_S_Y, 1'b0, 1'b0, DST_NONE);
            6'd41: u = mk_uop(OPA_C_Z, OPB_S_Z, 1'b0, 1'b0, DST_EDGE2);
            6'd42: u = mk_uop(OPA_S_X, OPB_TQ, 1'b0, 1'b1, DST_P_X);
            6'd43: u = mk_uop(OPA_S_Y, OPB_TQ, 1'b0, 1'b1, DST_P_Y);
            6'd44: u = mk_uop(OPA_S_Z, OPB_TQ, 1'b0, 1'b1, DST_P_Z);
            default: u = mk_uop(OPA_DIR_X, OPB_RANGE, 1'b0, 1'b1, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

### design/sth_ctrl.sv
`timescale 1ns / 1ps

module sth_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sth_pkg::ctrl_cmd_t cmd
);

    localparam logic [sth_pkg::DIG_IDX_W-1:0] LAST_DIG =
        sth_pkg::DIG_IDX_W'(sth_pkg::NDIG - 1);
    localparam logic [sth_pkg::DIV_CNT_W-1:0] LAST_DIV =
        sth_pkg::DIV_CNT_W'(sth_pkg::DIV_STEPS - 1);

    sth_pkg::ctrl_state_t state_reg, state_next;
    logic [sth_pkg::UOP_W-1:0]     uop_reg, uop_next;
    logic [sth_pkg::DIG_IDX_W-1:0] dig_reg, dig_next;
    logic [sth_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sth_pkg::ST_IDLE;
            uop_reg     <= '0;
            dig_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            uop_reg     <= uop_next;
            dig_reg     <= dig_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        uop_next     = uop_reg;
        dig_next     = dig_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.uop      = sth_pkg::uop_f(uop_reg);
        cmd.digit    = dig_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg) inside
            sth_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    uop_next    = '0;
                    dig_next    = '0;
                    state_next  = sth_pkg::ST_GEO;
                end
            end
            sth_pkg::ST_GEO, sth_pkg::ST_PNT: begin
                cmd.mac_en = 1'b1;
                if (dig_reg == LAST_DIG) begin
                    dig_next = '0;
                    uop_next = uop_reg + sth_pkg::UOP_W'(1);
                    if (uop_reg == sth_pkg::UOP_GEO_LAST) begin
                        state_next = sth_pkg::ST_ABS;
                    end else if (uop_reg == sth_pkg::UOP_LAST) begin
                        state_next = sth_pkg::ST_DONE;
                    end
                end else begin
                    dig_next = dig_reg + sth_pkg::DIG_IDX_W'(1);
                end
            end
            sth_pkg::ST_ABS: begin
                cmd.abs_load = 1'b1;
                cnt_next     = '0;
                state_next   = sth_pkg::ST_DIV;
            end
            sth_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + sth_pkg::DIV_CNT_W'(1);
                if (cnt_reg == LAST_DIV) begin
                    state_next = sth_pkg::ST_PNT;
                end
            end
            sth_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = sth_pkg::ST_IDLE;
                end
            end
            default: state_next = sth_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == sth_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### design/sth_dpath.sv
`timescale 1ns / 1ps

module sth_dpath #(
    parameter int FACE_INDEX_BITS = sth_pkg::FACE_INDEX_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sth_pkg::ctrl_cmd_t                  cmd,
    input  logic                                cfg_wr,
    input  logic [sth_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sth_pkg::CRD_W-1:0]           cfg_data,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v0_x,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v0_y,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v0_z,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v1_x,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v1_y,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v1_z,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v2_x,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v2_y,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v2_z,
    input  logic                                s_last_in,
    output logic                                m_hit,
    output logic                                m_first_hit,
    output logic signed [sth_pkg::CRD_W-1:0]    m_point_x,
    output logic signed [sth_pkg::CRD_W-1:0]    m_point_y,
    output logic signed [sth_pkg::CRD_W-1:0]    m_point_z,
    output logic [FACE_INDEX_BITS-1:0]          m_face_index,
    output logic                                m_last_out
);

    localparam int CRD_W   = sth_pkg::CRD_W;
    localparam int DIFF_W  = sth_pkg::DIFF_W;
    localparam int S_W     = sth_pkg::S_W;
    localparam int CROSS_W = sth_pkg::CROSS_W;
    localparam int OPA_W   = sth_pkg::OPA_W;
    localparam int OPB_W   = sth_pkg::OPB_W;
    localparam int DIG_W   = sth_pkg::DIG_W;
    localparam int ACC_W   = sth_pkg::ACC_W;
    localparam int PP_W    = OPA_W + DIG_W + 1;
    localparam int OFF_W   = sth_pkg::OFF_W;
    localparam int SUM_W   = sth_pkg::SUM_W;
    localparam int PT_SH   = sth_pkg::PT_SH;
    localparam int TQ_W    = sth_pkg::TQ_W;
    localparam int DIVQ_W  = sth_pkg::DIV_STEPS;

    logic signed [CRD_W-1:0]           origin_reg [3];
    logic signed [CRD_W-1:0]           dir_reg    [3];
    logic [sth_pkg::RANGE_W-1:0]       range_reg;

    logic signed [CRD_W-1:0]           vin        [3][3];
    logic signed [DIFF_W-1:0]          e0_reg     [3];
    logic signed [DIFF_W-1:0]          e1_reg     [3];
    logic signed [DIFF_W-1:0]          a_reg      [3][3];
    logic                              last_reg;
    logic signed [S_W-1:0]             s_reg      [3];
    logic signed [CROSS_W-1:0]         n_reg      [3];
    logic signed [CROSS_W-1:0]         c_reg      [3];
    logic signed [ACC_W-1:0]           den_reg, num_reg;
    logic [2:0]                        eneg_reg, ezero_reg;
    logic signed [CRD_W-1:0]           p_reg      [3];

    logic signed [ACC_W-1:0]           acc_reg, acc_next, acc_base, ppx;
    logic signed [OPA_W-1:0]           opa;
    logic signed [OPB_W-1:0]           opb;
    logic signed [DIG_W:0]             dig;
    logic signed [PP_W-1:0]            pp;

    logic [ACC_W-1:0]                  an_reg, ad_reg, r_reg, r_shl;
    logic [DIVQ_W-1:0]                 q_reg;
    logic                              ge_reg, hit_reg, hit_now;
    logic [TQ_W-1:0]                   tq;

    logic signed [CRD_W-1:0]           po;
    logic signed [OFF_W-1:0]           off;
    logic signed [SUM_W-1:0]           psum;
    logic signed [CRD_W-1:0]           psat;

    logic [FACE_INDEX_BITS-1:0]        face_cnt_reg;
    logic                              hit_seen_reg;
    logic                              m_hit_reg, m_first_reg, m_last_reg;
    logic signed [CRD_W-1:0]           m_px_reg, m_py_reg, m_pz_reg;
    logic [FACE_INDEX_BITS-1:0]        m_face_reg;
    logic                              mac_last;

    assign vin[0][0] = s_v0_x;
    assign vin[0][1] = s_v0_y;
    assign vin[0][2] = s_v0_z;
    assign vin[1][0] = s_v1_x;
    assign vin[1][1] = s_v1_y;
    assign vin[1][2] = s_v1_z;
    assign vin[2][0] = s_v2_x;
    assign vin[2][1] = s_v2_y;
    assign vin[2][2] = s_v2_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= 32'sd65536;
            range_reg     <= 31'd6553600;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                sth_pkg::CFG_ORIGIN_X:  origin_reg[0] <= cfg_data;
                sth_pkg::CFG_ORIGIN_Y:  origin_reg[1] <= cfg_data;
                sth_pkg::CFG_ORIGIN_Z:  origin_reg[2] <= cfg_data;
                sth_pkg::CFG_DIR_X:     dir_reg[0]    <= cfg_data;
                sth_pkg::CFG_DIR_Y:     dir_reg[1]    <= cfg_data;
                sth_pkg::CFG_DIR_Z:     dir_reg[2]    <= cfg_data;
                sth_pkg::CFG_SEG_RANGE: range_reg     <= cfg_data[sth_pkg::RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            for (int k = 0; k < 3; k++) begin
                e0_reg[k] <= DIFF_W'(vin[1][k]) - DIFF_W'(vin[0][k]);
                e1_reg[k] <= DIFF_W'(vin[2][k]) - DIFF_W'(vin[0][k]);
                for (int i = 0; i < 3; i++) begin
                    a_reg[i][k] <= DIFF_W'(vin[i][k]) - DIFF_W'(origin_reg[k]);
                end
            end
            last_reg <= s_last_in;
        end
    end

    always_comb begin
        unique case (cmd.uop.a)
            sth_pkg::OPA_DIR_X: opa = OPA_W'(dir_reg[0]);
            sth_pkg::OPA_DIR_Y: opa = OPA_W'(dir_reg[1]);
            sth_pkg::OPA_DIR_Z: opa = OPA_W'(dir_reg[2]);
            sth_pkg::OPA_E0_X:  opa = OPA_W'(e0_reg[0]);
            sth_pkg::OPA_E0_Y:  opa = OPA_W'(e0_reg[1]);
            sth_pkg::OPA_E0_Z:  opa = OPA_W'(e0_reg[2]);
            sth_pkg::OPA_A0_X:  opa = OPA_W'(a_reg[0][0]);
            sth_pkg::OPA_A0_Y:  opa = OPA_W'(a_reg[0][1]);
            sth_pkg::OPA_A0_Z:  opa = OPA_W'(a_reg[0][2]);
            sth_pkg::OPA_A1_X:  opa = OPA_W'(a_reg[1][0]);
            sth_pkg::OPA_A1_Y:  opa = OPA_W'(a_reg[1][1]);
            sth_pkg::OPA_A1_Z:  opa = OPA_W'(a_reg[1][2]);
            sth_pkg::OPA_A2_X:  opa = OPA_W'(a_reg[2][0]);
            sth_pkg::OPA_A2_Y:  opa = OPA_W'(a_reg[2][1]);
            sth_pkg::OPA_A2_Z:  opa = OPA_W'(a_reg[2][2]);
            sth_pkg::OPA_N_X:   opa = OPA_W'(n_reg[0]);
            sth_pkg::OPA_N_Y:   opa = OPA_W'(n_reg[1]);
            sth_pkg::OPA_N_Z:   opa = OPA_W'(n_reg[2]);
            sth_pkg::OPA_C_X:   opa = OPA_W'(c_reg[0]);
            sth_pkg::OPA_C_Y:   opa = OPA_W'(c_reg[1]);
            sth_pkg::OPA_C_Z:   opa = OPA_W'(c_reg[2]);
            sth_pkg::OPA_S_X:   opa = OPA_W'(s_reg[0]);
            sth_pkg::OPA_S_Y:   opa = OPA_W'(s_reg[1]);
            sth_pkg::OPA_S_Z:   opa = OPA_W'(s_reg[2]);
            default:            opa = '0;
        endcase
    end

    assign tq = ge_reg ? (TQ_W'(1) << PT_SH) : TQ_W'(q_reg);

    always_comb begin
        unique case (cmd.uop.b)
            sth_pkg::OPB_RANGE: opb = OPB_W'(range_reg);
            sth_pkg::OPB_E1_X:  opb = OPB_W'(e1_reg[0]);
            sth_pkg::OPB_E1_Y:  opb = OPB_W'(e1_reg[1]);
            sth_pkg::OPB_E1_Z:  opb = OPB_W'(e1_reg[2]);
            sth_pkg::OPB_A0_X:  opb = OPB_W'(a_reg[0][0]);
            sth_pkg::OPB_A0_Y:  opb = OPB_W'(a_reg[0][1]);
            sth_pkg::OPB_A0_Z:  opb = OPB_W'(a_reg[0][2]);
            sth_pkg::OPB_A1_X:  opb = OPB_W'(a_reg[1][0]);
            sth_pkg::OPB_A1_Y:  opb = OPB_W'(a_reg[1][1]);
            sth_pkg::OPB_A1_Z:  opb = OPB_W'(a_reg[1][2]);
            sth_pkg::OPB_A2_X:  opb = OPB_W'(a_reg[2][0]);
            sth_pkg::OPB_A2_Y:  opb = OPB_W'(a_reg[2][1]);
            sth_pkg::OPB_A2_Z:  opb = OPB_W'(a_reg[2][2]);
            sth_pkg::OPB_S_X:   opb = OPB_W'(s_reg[0]);
            sth_pkg::OPB_S_Y:   opb = OPB_W'(s_reg[1]);
            sth_pkg::OPB_S_Z:   opb = OPB_W'(s_reg[2]);
            sth_pkg::OPB_TQ:    opb = OPB_W'(tq);
            default:            opb = '0;
        endcase
    end

    // Low digits are unsigned, the top digit carries the sign of B.
    always_comb begin
        case (cmd.digit)
            2'd0:    dig = $signed({1'b0, opb[DIG_W-1:0]});
            2'd1:    dig = $signed({1'b0, opb[2*DIG_W-1:DIG_W]});
            default: dig = $signed({opb[OPB_W-1], opb[OPB_W-1:2*DIG_W]});
        endcase
    end

    assign pp = opa * dig;

    always_comb begin
        case (cmd.digit)
            2'd0:    ppx = ACC_W'(pp);
            2'd1:    ppx = ACC_W'(pp) <<< DIG_W;
            default: ppx = ACC_W'(pp) <<< (2 * DIG_W);
        endcase
        acc_base = (cmd.uop.clr && cmd.digit == '0) ? '0 : acc_reg;
        acc_next = cmd.uop.sub ? (acc_base - ppx) : (acc_base + ppx);
    end

    assign mac_last = cmd.mac_en && (cmd.digit == sth_pkg::DIG_IDX_W'(sth_pkg::NDIG - 1));

    always_comb begin
        case (cmd.uop.dst)
            sth_pkg::DST_P_Y: po = origin_reg[1];
            sth_pkg::DST_P_Z: po = origin_reg[2];
            default:          po = origin_reg[0];
        endcase
        off  = $signed(acc_next[PT_SH+OFF_W-1:PT_SH]);
        psum = SUM_W'(off) + SUM_W'(po);
        if (psum[SUM_W-1:CRD_W-1] == '0 || psum[SUM_W-1:CRD_W-1] == '1) begin
            psat = psum[CRD_W-1:0];
        end else if (psum[SUM_W-1]) begin
            psat = $signed({1'b1, {(CRD_W-1){1'b0}}});
        end else begin
            psat = $signed({1'b0, {(CRD_W-1){1'b1}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_en) begin
            acc_reg <= acc_next;
        end
        if (mac_last) begin
            unique case (cmd.uop.dst)
                sth_pkg::DST_S_X:   s_reg[0]     <= acc_next[S_W+DIG_W-1:DIG_W];
                sth_pkg::DST_S_Y:   s_reg[1]     <= acc_next[S_W+DIG_W-1:DIG_W];
                sth_pkg::DST_S_Z:   s_reg[2]     <= acc_next[S_W+DIG_W-1:DIG_W];
                sth_pkg::DST_N_X:   n_reg[0]     <= acc_next[CROSS_W-1:0];
                sth_pkg::DST_N_Y:   n_reg[1]     <= acc_next[CROSS_W-1:0];
                sth_pkg::DST_N_Z:   n_reg[2]     <= acc_next[CROSS_W-1:0];
                sth_pkg::DST_DEN:   den_reg      <= acc_next;
                sth_pkg::DST_NUM:   num_reg      <= acc_next;
                sth_pkg::DST_C_X:   c_reg[0]     <= acc_next[CROSS_W-1:0];
                sth_pkg::DST_C_Y:   c_reg[1]     <= acc_next[CROSS_W-1:0];
                sth_pkg::DST_C_Z:   c_reg[2]     <= acc_next[CROSS_W-1:0];
                sth_pkg::DST_EDGE0: begin
                    eneg_reg[0]  <= acc_next[ACC_W-1];
                    ezero_reg[0] <= (acc_next == '0);
                end
                sth_pkg::DST_EDGE1: begin
                    eneg_reg[1]  <= acc_next[ACC_W-1];
                    ezero_reg[1] <= (acc_next == '0);
                end
                sth_pkg::DST_EDGE2: begin
                    eneg_reg[2]  <= acc_next[ACC_W-1];
                    ezero_reg[2] <= (acc_next == '0);
                end
                sth_pkg::DST_P_X:   p_reg[0]     <= psat;
                sth_pkg::DST_P_Y:   p_reg[1]     <= psat;
                sth_pkg::DST_P_Z:   p_reg[2]     <= psat;
                default: ;
            endcase
        end
    end

    always_comb begin
        hit_now = (den_reg != '0)
            && (num_reg == '0 || num_reg[ACC_W-1] == den_reg[ACC_W-1])
            && (ad_reg >= an_reg);
        for (int i = 0; i < 3; i++) begin
            if (!ezero_reg[i] && eneg_reg[i] != den_reg[ACC_W-1]) begin
                hit_now = 1'b0;
            end
        end
    end

    assign r_shl = {r_reg[ACC_W-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.abs_load) begin
            an_reg <= num_reg[ACC_W-1] ? ACC_W'(-num_reg) : ACC_W'(num_reg);
            ad_reg <= den_reg[ACC_W-1] ? ACC_W'(-den_reg) : ACC_W'(den_reg);
            r_reg  <= num_reg[ACC_W-1] ? ACC_W'(-num_reg) : ACC_W'(num_reg);
            q_reg  <= '0;
        end else if (cmd.div_step) begin
            if (r_shl >= ad_reg) begin
                r_reg <= r_shl - ad_reg;
                q_reg <= {q_reg[DIVQ_W-2:0], 1'b1};
            end else begin
                r_reg <= r_shl;
                q_reg <= {q_reg[DIVQ_W-2:0], 1'b0};
            end
            ge_reg  <= (an_reg >= ad_reg);
            hit_reg <= hit_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_cnt_reg <= '0;
            hit_seen_reg <= 1'b0;
        end else if (cmd.out_load) begin
            if (last_reg) begin
                face_cnt_reg <= '0;
                hit_seen_reg <= 1'b0;
            end else begin
                face_cnt_reg <= face_cnt_reg + FACE_INDEX_BITS'(1);
                if (hit_reg) begin
                    hit_seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hit_reg   <= hit_reg;
            m_first_reg <= hit_reg && !hit_seen_reg;
            m_px_reg    <= hit_reg ? p_reg[0] : '0;
            m_py_reg    <= hit_reg ? p_reg[1] : '0;
            m_pz_reg    <= hit_reg ? p_reg[2] : '0;
            m_face_reg  <= face_cnt_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_hit        = m_hit_reg;
    assign m_first_hit  = m_first_reg;
    assign m_point_x    = m_px_reg;
    assign m_point_y    = m_py_reg;
    assign m_point_z    = m_pz_reg;
    assign m_face_index = m_face_reg;
    assign m_last_out   = m_last_reg;

endmodule

### design/segment_triangle_hit_test.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_v0_x .. s_v2_z, s_last_in
// m_        m_valid / m_ready    m_hit, m_first_hit, m_point_x/y/z, m_face_index, m_last_out
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each triangle runs on the shared 68x17 multiply-accumulate unit (45 products, three
// 16-bit digits each): 42 geometry products, a magnitude setup, the restoring divider,
// then the three crossing-point products and the hand-off to the output register.
// A new triangle is taken only once the previous one has moved into the output register.
// Reset (aresetn low, synchronous) restores register defaults and clears the face
// counter and first-hit tracking. A stalled m_ready holds the result and the core.

module segment_triangle_hit_test #(
    parameter int FACE_INDEX_BITS = sth_pkg::FACE_INDEX_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v0_x,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v0_y,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v0_z,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v1_x,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v1_y,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v1_z,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v2_x,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v2_y,
    input  logic signed [sth_pkg::CRD_W-1:0]    s_v2_z,
    input  logic                                s_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic                                m_first_hit,
    output logic signed [sth_pkg::CRD_W-1:0]    m_point_x,
    output logic signed [sth_pkg::CRD_W-1:0]    m_point_y,
    output logic signed [sth_pkg::CRD_W-1:0]    m_point_z,
    output logic [FACE_INDEX_BITS-1:0]          m_face_index,
    output logic                                m_last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sth_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sth_pkg::CRD_W-1:0]           cfg_data
);

    sth_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sth_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sth_dpath #(
        .FACE_INDEX_BITS (FACE_INDEX_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_v0_x       (s_v0_x),
        .s_v0_y       (s_v0_y),
        .s_v0_z       (s_v0_z),
        .s_v1_x       (s_v1_x),
        .s_v1_y       (s_v1_y),
        .s_v1_z       (s_v1_z),
        .s_v2_x       (s_v2_x),
        .s_v2_y       (s_v2_y),
        .s_v2_z       (s_v2_z),
        .s_last_in    (s_last_in),
        .m_hit        (m_hit),
        .m_first_hit  (m_first_hit),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_point_z    (m_point_z),
        .m_face_index (m_face_index),
        .m_last_out   (m_last_out)
    );

`include "assert_macros.svh"

    `STH_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second transaction taken while busy")
    `STH_ASSERT_NOW(a_first_is_hit, m_valid && m_first_hit, m_hit, "first hit flagged on a miss")
    `STH_ASSERT_NOW(a_miss_point_zero, m_valid && !m_hit, m_point_x == 0 && m_point_y == 0 && m_point_z == 0, "miss carries a nonzero point")

endmodule

### tb/sv/segment_triangle_hit_test_tb.sv
`timescale 1ns / 1ps

module segment_triangle_hit_test_tb;

    localparam int  Q1         = 65536;
    localparam int  IDLE_LIMIT = 20000;
    localparam int  LONG_HOLD  = 3000;
    localparam logic [sth_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [8:0][31:0] c;
        logic             last;
    } tri_t;

    typedef struct packed {
        logic        hit;
        logic        first;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] face;
        logic        last;
    } hit_t;

    typedef struct packed {
        tri_t tr;
        logic typed;
        hit_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic signed [31:0] s_v0_x = 0, s_v0_y = 0, s_v0_z = 0;
    logic signed [31:0] s_v1_x = 0, s_v1_y = 0, s_v1_z = 0;
    logic signed [31:0] s_v2_x = 0, s_v2_y = 0, s_v2_z = 0;
    logic s_last_in = 1'b0;
    logic m_valid, m_ready = 1'b0;
    logic m_hit, m_first_hit, m_last_out;
    logic signed [31:0] m_point_x, m_point_y, m_point_z;
    logic [15:0] m_face_index;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [sth_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #6 aclk = ~aclk;

    segment_triangle_hit_test dut (.*);

    logic signed [31:0] org [3];
    logic signed [31:0] dirv [3];
    logic [30:0]        rng;
    logic [15:0]        face_cnt;
    logic               seen_hit;
    hit_t               pending_hits [$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    logic               long_hold_req = 1'b0;
    logic               gaps_on = 1'b1;

    function automatic logic signed [127:0] seg_comp(int k);
        logic signed [127:0] p;
        p = dirv[k];
        p = p * $signed({97'b0, rng});
        return p >>> 16;
    endfunction

    function automatic logic signed [127:0] dot_s(logic signed [127:0] w [3],
                                                 logic signed [127:0] s [3]);
        return w[0] * s[0] + w[1] * s[1] + w[2] * s[2];
    endfunction

    function automatic hit_t predict_hit(tri_t t);
        logic signed [127:0] v [3][3];
        logic signed [127:0] a [3][3];
        logic signed [127:0] s [3];
        logic signed [127:0] e0 [3];
        logic signed [127:0] e1 [3];
        logic signed [127:0] n [3];
        logic signed [127:0] c [3];
        logic signed [127:0] den, num, an, ad, ed, pr, qv;
        logic [191:0] quo;
        logic [32:0]  tq;
        logic         hit;
        logic signed [31:0] pt [3];
        hit_t r;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            pt[k] = 0;
            s[k] = seg_comp(k);
            for (int i = 0; i < 3; i++) begin
                v[i][k] = $signed(t.c[i * 3 + k]);
                a[i][k] = v[i][k] - org[k];
            end
            e0[k] = v[1][k] - v[0][k];
            e1[k] = v[2][k] - v[0][k];
        end
        n[0] = e0[1] * e1[2] - e0[2] * e1[1];
        n[1] = e0[2] * e1[0] - e0[0] * e1[2];
        n[2] = e0[0] * e1[1] - e0[1] * e1[0];
        den = dot_s(n, s);
        num = dot_s(n, a[0]);
        if (den != 0) begin
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            hit = (num == 0 || ((num < 0) == (den < 0))) && ad >= an;
            for (int i = 0; i < 3; i++) begin
                c[0] = a[i][1] * a[(i + 1) % 3][2] - a[i][2] * a[(i + 1) % 3][1];
                c[1] = a[i][2] * a[(i + 1) % 3][0] - a[i][0] * a[(i + 1) % 3][2];
                c[2] = a[i][0] * a[(i + 1) % 3][1] - a[i][1] * a[(i + 1) % 3][0];
                ed = dot_s(c, s);
                if (ed != 0 && ((ed < 0) != (den < 0))) hit = 1'b0;
            end
            if (hit) begin
                if (an >= ad) begin
                    tq = 33'h1_0000_0000;
                end else begin
                    quo = ({64'b0, an} << 32) / {64'b0, ad};
                    tq = quo[32:0];
                end
                for (int k = 0; k < 3; k++) begin
                    pr = s[k] * $signed({95'b0, tq});
                    qv = org[k] + (pr >>> 32);
                    if (qv > 128'sd2147483647) qv = 128'sd2147483647;
                    if (qv < -128'sd2147483648) qv = -128'sd2147483648;
                    pt[k] = qv[31:0];
                end
            end
        end
        r.hit = hit;
        r.first = hit && !seen_hit;
        r.px = pt[0];
        r.py = pt[1];
        r.pz = pt[2];
        r.face = face_cnt;
        r.last = t.last;
        if (t.last) begin
            face_cnt = 0;
            seen_hit = 1'b0;
        end else begin
            face_cnt = face_cnt + 1'b1;
            if (hit) seen_hit = 1'b1;
        end
        return r;
    endfunction

    task automatic write_reg(logic [sth_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sth_pkg::CFG_ORIGIN_X:  org[0] = val;
            sth_pkg::CFG_ORIGIN_Y:  org[1] = val;
            sth_pkg::CFG_ORIGIN_Z:  org[2] = val;
            sth_pkg::CFG_DIR_X:     dirv[0] = val;
            sth_pkg::CFG_DIR_Y:     dirv[1] = val;
            sth_pkg::CFG_DIR_Z:     dirv[2] = val;
            sth_pkg::CFG_SEG_RANGE: rng = val[30:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [31:0] o0, logic [31:0] o1, logic [31:0] o2,
                             logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                             logic [31:0] r);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        write_reg(sth_pkg::CFG_ORIGIN_X, o0);
        write_reg(sth_pkg::CFG_ORIGIN_Y, o1);
        write_reg(sth_pkg::CFG_ORIGIN_Z, o2);
        write_reg(sth_pkg::CFG_DIR_X, d0);
        write_reg(sth_pkg::CFG_DIR_Y, d1);
        write_reg(sth_pkg::CFG_DIR_Z, d2);
        write_reg(sth_pkg::CFG_SEG_RANGE, r);
        write_reg(CFG_UNUSED, $urandom());
    endtask

    int burst_left = 0;

    task automatic send_tri(tri_t t, logic typed, hit_t typed_res);
        hit_t p;
        if (gaps_on && burst_left == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge aclk);
            burst_left = $urandom_range(1, 8);
        end else begin
            @(negedge aclk);
        end
        if (burst_left > 0) burst_left--;
        s_valid = 1'b1;
        {s_v0_x, s_v0_y, s_v0_z, s_v1_x, s_v1_y, s_v1_z, s_v2_x, s_v2_y, s_v2_z} =
            {t.c[0], t.c[1], t.c[2], t.c[3], t.c[4], t.c[5], t.c[6], t.c[7], t.c[8]};
        s_last_in = t.last;
        do @(posedge aclk); while (!s_ready);
        p = predict_hit(t);
        pending_hits.push_back(typed ? typed_res : p);
    endtask

    function automatic logic [31:0] q16(int x);
        return x * Q1;
    endfunction

    function automatic tri_t mk_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                    int c0, int c1, int c2, logic last);
        tri_t t;
        t.c = {q16(c2), q16(c1), q16(c0), q16(b2), q16(b1), q16(b0),
               q16(a2), q16(a1), q16(a0)};
        t.last = last;
        return t;
    endfunction

    function automatic hit_t mk_res(logic h, logic f, int pz, int face, logic last);
        hit_t r;
        r.hit = h;
        r.first = f;
        r.px = 0;
        r.py = 0;
        r.pz = q16(pz);
        r.face = face;
        r.last = last;
        return r;
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        logic signed [127:0] p, tp;
        int span;
        t.last = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 9; i++) t.c[i] = $urandom();
            t.last = $urandom_range(0, 1);
        end else begin
            tp = $signed($urandom_range(0, Q1 + 4000)) - 2000;
            span = 1 << $urandom_range(4, 22);
            for (int k = 0; k < 3; k++) begin
                p = org[k] + ((seg_comp(k) * tp) >>> 16);
                for (int i = 0; i < 3; i++)
                    t.c[i * 3 + k] = p[31:0] + $urandom_range(0, 2 * span) - span;
            end
        end
        return t;
    endfunction

    always @(posedge aclk) begin
        hit_t e;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("segment_triangle_hit_test_tb: FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $error("result transaction with no expectation");
                errors++;
            end else begin
                e = pending_hits.pop_front();
                if (m_hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, m_hit); errors++;
                end
                if (m_first_hit !== e.first) begin
                    $error("first_hit exp %0d got %0d", e.first, m_first_hit); errors++;
                end
                if (m_point_x !== e.px) begin
                    $error("point_x exp %h got %h", e.px, m_point_x); errors++;
                end
                if (m_point_y !== e.py) begin
                    $error("point_y exp %h got %h", e.py, m_point_y); errors++;
                end
                if (m_point_z !== e.pz) begin
                    $error("point_z exp %h got %h", e.pz, m_point_z); errors++;
                end
                if (m_face_index !== e.face) begin
                    $error("face_index exp %0d got %0d", e.face, m_face_index); errors++;
                end
                if (m_last_out !== e.last) begin
                    $error("last_out exp %0d got %0d", e.last, m_last_out); errors++;
                end
            end
        end
    end

    initial begin
        int hold;
        int mode;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            mode = $urandom_range(0, 199);
            if (hold > 0) begin
                hold--;
                m_ready = 1'b0;
            end else if (mode < 3) begin
                hold = $urandom_range(20, 300);
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 3) != 0) || mode > 120;
            end
        end
    end

    row_t rows [$];
    hit_t none_res;
    tri_t t;

    initial begin
        org[0] = 0; org[1] = 0; org[2] = 0;
        dirv[0] = 0; dirv[1] = 0; dirv[2] = Q1;
        rng = 31'd6553600;
        face_cnt = 0;
        seen_hit = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        rows.push_back({mk_tri(-1, -1, 50, 1, -1, 50, 0, 1, 50, 0), 1'b1,
                        mk_res(1, 1, 50, 0, 0)});
        rows.push_back({mk_tri(-1, -1, 50, 1, -1, 50, 0, 1, 50, 1), 1'b1,
                        mk_res(1, 0, 50, 1, 1)});
        rows.push_back({mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_res(0, 0, 0, 0, 0)});
        rows.push_back({mk_tri(0, 0, 100, 1, 0, 100, 0, 1, 100, 0), 1'b1,
                        mk_res(1, 1, 100, 1, 0)});
        rows.push_back({mk_tri(-1, 0, 0, 1, 0, 0, 0, 1, 0, 0), 1'b1,
                        mk_res(1, 0, 0, 2, 0)});
        rows.push_back({mk_tri(-1, -1, -5, 1, -1, -5, 0, 1, -5, 0), 1'b1,
                        mk_res(0, 0, 0, 3, 0)});
        rows.push_back({mk_tri(-1, -1, 200, 1, -1, 200, 0, 1, 200, 0), 1'b1,
                        mk_res(0, 0, 0, 4, 0)});
        rows.push_back({mk_tri(0, -1, 0, 0, 1, 0, 0, 0, 9, 0), 1'b1,
                        mk_res(0, 0, 0, 5, 0)});
        rows.push_back({mk_tri(3, 3, 50, 5, 3, 50, 4, 5, 50, 0), 1'b1,
                        mk_res(0, 0, 0, 6, 0)});
        t.c = {9{32'h7fff_ffff}}; t.last = 0;
        rows.push_back({t, 1'b0, none_res});
        t.c = {9{32'h8000_0000}};
        rows.push_back({t, 1'b0, none_res});
        t.c = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
               32'h0000_0001};
        rows.push_back({t, 1'b0, none_res});
        t.c = {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
               32'hffff_ffff};
        t.last = 1;
        rows.push_back({t, 1'b0, none_res});
        foreach (rows[i]) send_tri(rows[i].tr, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
                1: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
                2: write_all($urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom());
                3: write_all(32'h8000_0000, 32'h7fff_ffff, 32'h0,
                             32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff);
                default: write_all($urandom_range(0, 1 << 25) - (1 << 24),
                                   $urandom_range(0, 1 << 25) - (1 << 24),
                                   $urandom_range(0, 1 << 25) - (1 << 24),
                                   $urandom_range(0, 2 * Q1) - Q1,
                                   $urandom_range(0, 2 * Q1) - Q1,
                                   $urandom_range(0, 2 * Q1) - Q1,
                                   $urandom_range(Q1, 1 << 24));
            endcase
            gaps_on = (ph % 3 != 1);
            if (ph == 5) long_hold_req = 1'b1;
            repeat (ph < 4 ? 80 : 224) send_tri(rand_tri(), 1'b0, none_res);
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("segment_triangle_hit_test_tb: PASS");
        end else begin
            $display("segment_triangle_hit_test_tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/sth_pkg.sv
design/sth_ctrl.sv
design/sth_dpath.sv
design/segment_triangle_hit_test.sv
tb/sv/segment_triangle_hit_test_tb.sv
